[design/wsfp_pkg.sv]
// ----------------------------------------------------------------------------
// wsfp_pkg
// Shared types and constants of the WebSocket receive frame parser.
// ----------------------------------------------------------------------------
package wsfp_pkg;

  localparam int unsigned MaxPayloadW = 63;
  localparam int unsigned LenW        = 64;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = MaxPayloadW;

  localparam logic [MaxPayloadW-1:0] MaxPayloadRst = MaxPayloadW'(16777216);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxPayload = 1'b0,
    CfgExtActive  = 1'b1
  } wsfp_cfg_idx_e;

  // Result kinds
  typedef enum logic [1:0] {
    KindHeader  = 2'd0,
    KindPayload = 2'd1,
    KindError   = 2'd2,
    KindIgnored = 2'd3
  } wsfp_kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    StNone     = 2'd0,
    StProto    = 2'd1,
    StUnmasked = 2'd2,
    StLarge    = 2'd3
  } wsfp_status_e;

  // Parser phases, one-hot
  typedef enum logic [4:0] {
    PhHdr0    = 5'b00001,
    PhHdr1    = 5'b00010,
    PhExtLen  = 5'b00100,
    PhMask    = 5'b01000,
    PhPayload = 5'b10000
  } wsfp_phase_e;

  // Frame opcodes; all but OpText are referenced by the checks
  localparam logic [3:0] OpCont    = 4'h0;
  localparam logic [3:0] OpText    = 4'h1;
  localparam logic [3:0] OpBinary  = 4'h2;
  localparam logic [3:0] OpCtlBase = 4'h8;
  localparam logic [3:0] OpPong    = 4'hA;

  // Length codes in the second header byte
  localparam logic [6:0] Len7Ext16 = 7'd126;
  localparam logic [6:0] Len7Ext64 = 7'd127;

  // Extended length byte counts
  localparam logic [3:0] ExtBytes16 = 4'd2;
  localparam logic [3:0] ExtBytes64 = 4'd8;

  // Live configuration
  typedef struct packed {
    logic [MaxPayloadW-1:0] len_limit;
    logic                   extensions_active;
  } wsfp_cfg_t;

  // One result beat
  typedef struct packed {
    wsfp_kind_e             kind;
    logic [7:0]             data_out;
    logic [3:0]             opcode;
    logic                   fin;
    logic                   first_fragment;
    logic                   frame_end;
    wsfp_status_e           status;
    logic [MaxPayloadW-1:0] frame_len;
  } wsfp_result_t;

endpackage

[design/wsfp_if.sv]
// ----------------------------------------------------------------------------
// wsfp_if
// Valid/ready channels of the frame parser: byte input and result output.
// ----------------------------------------------------------------------------
interface wsfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface wsfp_out_if
  import wsfp_pkg::*;
;
  logic         valid;
  logic         ready;
  wsfp_result_t result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

[design/websocket_frame_rx_parser_unit.sv]
// ----------------------------------------------------------------------------
// websocket_frame_rx_parser_unit
// Client-to-server WebSocket frame parser: header checks, length decode,
// mask key capture and payload unmasking, one result beat per input byte.
// ----------------------------------------------------------------------------
//  Channel  Dir  Beat                          Handshake
//  in_i     in   one stream byte (byte_in)     valid/ready
//  out_o    out  one result (wsfp_result_t)    valid/ready
//  cfg      in   register write, idx + data    cfg_we_i, no stall
//
//  Each byte is decoded in the cycle it is accepted and its result appears in
//  the output register on the next cycle; one byte per clock unless out_o stalls.
//  The output register decouples the sides: a byte is taken whenever the
//  register is empty or its beat is being taken the same cycle.
//  Reset clears parse state, not the mask key, and loads the config reset values.
//  An error result halts parsing; later bytes give ignored beats until reset.
// ----------------------------------------------------------------------------
module websocket_frame_rx_parser_unit
  import wsfp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  wsfp_in_if.sink             in_i,
  wsfp_out_if.source          out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  wsfp_cfg_t    cfg_q;
  wsfp_result_t result_d, result_q;
  logic         out_valid_q;
  logic         accept;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.len_limit         <= MaxPayloadRst;
      cfg_q.extensions_active <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (wsfp_cfg_idx_e'(cfg_idx_i))
        CfgMaxPayload: cfg_q.len_limit         <= cfg_data_i[MaxPayloadW-1:0];
        CfgExtActive:  cfg_q.extensions_active <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  wsfp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (in_i.byte_in),
    .cfg_i    (cfg_q),
    .result_o (result_d)
  );

  // Output register: load on accept, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.result = result_q;

endmodule

[design/wsfp_parser.sv]
// ----------------------------------------------------------------------------
// wsfp_parser
// Frame parse state and the single-pass next-state / result logic per byte.
// ----------------------------------------------------------------------------
module wsfp_parser
  import wsfp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic [7:0]   byte_i,
  input  wsfp_cfg_t    cfg_i,
  output wsfp_result_t result_o
);

  wsfp_phase_e      phase_q, phase_d;
  logic             in_control_q, in_control_d;
  logic             frag_open_q, frag_open_d;
  logic [3:0]       msg_op_q, msg_op_d;
  logic             frame_fin_q, frame_fin_d;
  logic [3:0]       frame_op_q, frame_op_d;
  logic [3:0]       len_seen_q, len_seen_d;
  logic [LenW-1:0]  len_acc_q, len_acc_d;
  logic             ext64_q, ext64_d;
  logic [1:0]       mask_idx_q, mask_idx_d;
  logic [LenW-1:0]  bytes_rem_q, bytes_rem_d;
  logic             halted_q, halted_d;
  logic [7:0]       key_q [4];
  logic             key_we;

  // Per-byte decode
  always_comb begin
    logic [3:0]   op;
    logic         fin;
    logic         ctl;
    logic         reserved;
    logic         fail;
    logic         len_done;
    logic         frame_end;
    logic [7:0]   data;
    wsfp_kind_e   kind;
    wsfp_status_e status;
    logic [3:0]   ext_total;

    phase_d      = phase_q;
    in_control_d = in_control_q;
    frag_open_d  = frag_open_q;
    msg_op_d     = msg_op_q;
    frame_fin_d  = frame_fin_q;
    frame_op_d   = frame_op_q;
    len_seen_d   = len_seen_q;
    len_acc_d    = len_acc_q;
    ext64_d      = ext64_q;
    mask_idx_d   = mask_idx_q;
    bytes_rem_d  = bytes_rem_q;
    halted_d     = halted_q;
    key_we       = 1'b0;

    op        = byte_i[3:0];
    fin       = byte_i[7];
    ctl       = (op >= OpCtlBase);
    reserved  = ((op > OpBinary) && (op < OpCtlBase)) || (op > OpPong);
    fail      = 1'b0;
    len_done  = 1'b0;
    frame_end = 1'b0;
    data      = 8'd0;
    kind      = KindHeader;
    status    = StNone;
    ext_total = ext64_q ? ExtBytes64 : ExtBytes16;

    unique case (phase_q)
      PhHdr0: begin
        frame_fin_d = fin;
        frame_op_d  = op;
        len_acc_d   = '0;
        len_seen_d  = '0;
        priority if (!cfg_i.extensions_active && (byte_i[6:4] != 3'd0)) begin
          fail = 1'b1; status = StProto;
        end else if (reserved) begin
          fail = 1'b1; status = StProto;
        end else if (ctl && !fin) begin
          fail = 1'b1; status = StProto;
        end else if (!ctl && (op == OpCont) && !frag_open_q) begin
          fail = 1'b1; status = StProto;
        end else if (!ctl && (op != OpCont) && frag_open_q) begin
          fail = 1'b1; status = StProto;
        end else begin
          if (ctl) begin
            in_control_d = 1'b1;
          end else begin
            if (op != OpCont) begin
              msg_op_d = op;
            end
            frag_open_d  = !fin;
            in_control_d = 1'b0;
          end
          phase_d = PhHdr1;
        end
      end
      PhHdr1: begin
        priority if (!byte_i[7]) begin
          fail = 1'b1; status = StUnmasked;
        end else if (byte_i[6:0] < Len7Ext16) begin
          len_acc_d = LenW'(byte_i[6:0]);
          len_done  = 1'b1;
        end else if (in_control_q) begin
          fail = 1'b1; status = StProto;
        end else begin
          ext64_d    = (byte_i[6:0] == Len7Ext64);
          len_seen_d = '0;
          len_acc_d  = '0;
          phase_d    = PhExtLen;
        end
      end
      PhExtLen: begin
        len_acc_d  = {len_acc_q[LenW-9:0], byte_i};
        len_seen_d = len_seen_q + 4'd1;
        len_done   = (len_seen_d >= ext_total);
      end
      PhMask: begin
        key_we = 1'b1;
        if (mask_idx_q == 2'd3) begin
          mask_idx_d = 2'd0;
          if (bytes_rem_q == '0) begin
            phase_d   = PhHdr0;
            frame_end = 1'b1;
          end else begin
            phase_d = PhPayload;
          end
        end else begin
          mask_idx_d = mask_idx_q + 2'd1;
        end
      end
      PhPayload: begin
        kind       = KindPayload;
        data       = byte_i ^ key_q[mask_idx_q];
        mask_idx_d = mask_idx_q + 2'd1;
        if (bytes_rem_q != '0) begin
          bytes_rem_d = bytes_rem_q - LenW'(1);
        end
        frame_end = (bytes_rem_d == '0);
        if (frame_end) begin
          phase_d = PhHdr0;
        end
      end
      default: begin
        phase_d = PhHdr0;
      end
    endcase

    // Length complete: bound check, then go collect the mask key
    if (len_done) begin
      if (len_acc_d > {1'b0, cfg_i.len_limit}) begin
        fail   = 1'b1;
        status = StLarge;
      end else begin
        bytes_rem_d = len_acc_d;
        mask_idx_d  = 2'd0;
        phase_d     = PhMask;
      end
    end

    if (fail) begin
      halted_d  = 1'b1;
      kind      = KindError;
      data      = 8'd0;
      frame_end = 1'b0;
    end

    result_o.kind           = kind;
    result_o.data_out       = data;
    result_o.opcode         = (frame_op_d == OpCont) ? msg_op_d : frame_op_d;
    result_o.fin            = frame_fin_d;
    result_o.first_fragment = (frame_op_d != OpCont);
    result_o.frame_end      = frame_end;
    result_o.status         = status;
    result_o.frame_len      = len_acc_d[MaxPayloadW-1:0];

    // After halt: drop every byte, hold all state
    if (halted_q) begin
      result_o      = '0;
      result_o.kind = KindIgnored;
      phase_d       = phase_q;
      in_control_d  = in_control_q;
      frag_open_d   = frag_open_q;
      msg_op_d      = msg_op_q;
      frame_fin_d   = frame_fin_q;
      frame_op_d    = frame_op_q;
      len_seen_d    = len_seen_q;
      len_acc_d     = len_acc_q;
      ext64_d       = ext64_q;
      mask_idx_d    = mask_idx_q;
      bytes_rem_d   = bytes_rem_q;
      halted_d      = halted_q;
      key_we        = 1'b0;
    end
  end

  // Advance parse state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhHdr0;
      in_control_q <= 1'b0;
      frag_open_q  <= 1'b0;
      msg_op_q     <= '0;
      frame_fin_q  <= 1'b0;
      frame_op_q   <= '0;
      len_seen_q   <= '0;
      len_acc_q    <= '0;
      ext64_q      <= 1'b0;
      mask_idx_q   <= '0;
      bytes_rem_q  <= '0;
      halted_q     <= 1'b0;
    end else if (accept_i) begin
      phase_q      <= phase_d;
      in_control_q <= in_control_d;
      frag_open_q  <= frag_open_d;
      msg_op_q     <= msg_op_d;
      frame_fin_q  <= frame_fin_d;
      frame_op_q   <= frame_op_d;
      len_seen_q   <= len_seen_d;
      len_acc_q    <= len_acc_d;
      ext64_q      <= ext64_d;
      mask_idx_q   <= mask_idx_d;
      bytes_rem_q  <= bytes_rem_d;
      halted_q     <= halted_d;
    end
  end

  // Capture mask key bytes
  always_ff @(posedge clk_i) begin
    if (accept_i && key_we) begin
      key_q[mask_idx_q] <= byte_i;
    end
  end

endmodule

[design/wsfp_checker.sv]
// ----------------------------------------------------------------------------
// wsfp_checker
// Port-level checks of the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module wsfp_checker
  import wsfp_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_valid_i,
  input logic         in_ready_i,
  input logic         out_valid_i,
  input logic         out_ready_i,
  input wsfp_result_t result_i
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(result_i))
    else $error("stalled result beat changed");

  // Take input exactly when the output register has room
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not follow output register");

  // Every accepted byte gives a result beat next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted byte gave no result");

  // Ignored beats carry no content
  a_ignored_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_i.kind == KindIgnored) |->
      (result_i.data_out == 8'd0) && (result_i.status == StNone) &&
      !result_i.frame_end && (result_i.frame_len == '0))
    else $error("ignored beat carries content");

endmodule

bind websocket_frame_rx_parser_unit wsfp_checker u_wsfp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .result_i    (out_o.result)
);
